// ----- hdl/ofta_pkg.sv -----
// ----------------------------------------------------------------------------
// ofta_pkg: shared types and constants for the outlier filtered timing average
// Word layouts of both channels, the controller states and the fixed
// constants of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package ofta_pkg;

	localparam int MAX_SAMPLES_DEF = 64;
	localparam int SAMPLE_W        = 32;
	localparam int FACTOR_W        = 4;
	localparam int MEAN_W          = 40;
	localparam int FRAC_W          = 8;
	localparam int COUNT_OUT_W     = 7;
	localparam int PCT_W           = 7;
	localparam int THRESH_W        = SAMPLE_W + FACTOR_W;
	localparam int PCT_SCALE       = 100;

	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 4'd3;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_time;
		logic                last_sample;
	} in_word_t;

	typedef struct packed {
		logic [MEAN_W-1:0]      plain_mean;
		logic [MEAN_W-1:0]      filtered_mean;
		logic                   filtered_valid;
		logic [COUNT_OUT_W-1:0] outlier_count;
		logic [PCT_W-1:0]       outlier_percent;
		logic                   overflow;
	} out_word_t;

	typedef enum logic [2:0] {
		S_LOAD,
		S_THRESH,
		S_SCAN,
		S_DIV_PLAIN,
		S_DIV_FILT,
		S_DIV_PCT,
		S_FINISH
	} state_t;

endpackage

`default_nettype wire

// ----- hdl/ofta_div.sv -----
// ----------------------------------------------------------------------------
// ofta_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle. Operands are captured on
// start; done pulses for one cycle once the quotient register is final.
// ----------------------------------------------------------------------------
`default_nettype none

module ofta_div #(
	parameter int NUM_W = 47,
	parameter int DEN_W = 7
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] dividend,
	input  wire logic [DEN_W-1:0] divisor,
	output logic                  done,
	output logic [NUM_W-1:0]      quotient
);

	localparam int STEP_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  dvs_q;

	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              fits;
	logic [DEN_W-1:0]  rem_nxt;

	always_comb begin
		trial   = {rem_q, quo_q[NUM_W-1]};
		diff    = trial - {1'b0, dvs_q};
		fits    = (trial >= {1'b0, dvs_q});
		rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(NUM_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= rem_nxt;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ----- hdl/outlier_filtered_timing_average.sv -----
// ----------------------------------------------------------------------------
// outlier_filtered_timing_average: min-relative outlier filtered mean
// Collects a set of timing samples in a local memory and reports the plain
// mean, the mean of the non-outliers, the outlier count and percentage.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one sample word per handshake, last_sample marks the end of a set.
//            Samples load at one per cycle while in_ready is high; past
//            MAX_SAMPLES they are dropped and the overflow flag of the result is set.
//   cfg_*  : writes outlier_factor; write it only while no set is in flight.
//   out_*  : one result word per set, held in an output register until taken.
// Evaluation after the last sample: a threshold step, a scan of the sample
//   memory (one read port, one sample per cycle, then the last compare and
//   the divider start), then three runs of the shared bit-serial divider,
//   DIV_W = 40+clog2(MAX_SAMPLES+1) bits wide, and finally the load of the
//   result register.
// While a set is being evaluated in_ready stays low. Once the result is in
//   the output register the next set may load even if the receiver stalls;
//   evaluation of that set holds in its last step until the register frees.
// Reset empties the set and sets outlier_factor to 3; memory contents are
//   not cleared, only entries written in the current set are read.
// ----------------------------------------------------------------------------
`default_nettype none

module outlier_filtered_timing_average #(
	parameter int MAX_SAMPLES = ofta_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire ofta_pkg::in_word_t                in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output ofta_pkg::out_word_t                    out_data,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [ofta_pkg::FACTOR_W-1:0]     cfg_data
);

	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int SUM_W  = ofta_pkg::SAMPLE_W + CNT_W;
	localparam int DIV_W  = SUM_W + ofta_pkg::FRAC_W;
	localparam int SW     = ofta_pkg::SAMPLE_W;
	localparam int TW     = ofta_pkg::THRESH_W;

	ofta_pkg::state_t state_q, state_nxt;

	logic [SW-1:0] mem [MAX_SAMPLES];

	logic [ofta_pkg::FACTOR_W-1:0] factor_q;
	logic [SW-1:0]    min_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] sum_q;
	logic             drop_q;

	logic [TW-1:0]    thresh_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             rd_pend_s1;
	logic [SW-1:0]    rd_data_s1;
	logic [CNT_W-1:0] outl_q;
	logic [SUM_W-1:0] fsum_q;

	logic [ofta_pkg::MEAN_W-1:0] plain_q;
	logic [ofta_pkg::MEAN_W-1:0] filt_q;
	logic [ofta_pkg::PCT_W-1:0]  pct_q;

	ofta_pkg::out_word_t out_q;
	logic                out_valid_q;

	logic             in_acc;
	logic             has_room;
	logic             rd_issue;
	logic             scan_done;
	logic             div_start;
	logic             div_done;
	logic [DIV_W-1:0] div_num;
	logic [CNT_W-1:0] div_den;
	logic [DIV_W-1:0] div_quo;
	logic [CNT_W-1:0] kept;
	logic             load_out;

	assign in_acc    = in_valid && in_ready;
	assign has_room  = (cnt_q < CNT_W'(MAX_SAMPLES));
	assign kept      = cnt_q - outl_q;
	assign rd_issue  = (state_q == ofta_pkg::S_SCAN) && (rd_idx_q < cnt_q);
	assign scan_done = (state_q == ofta_pkg::S_SCAN) && !rd_issue && !rd_pend_s1;
	assign load_out  = (state_q == ofta_pkg::S_FINISH) && (!out_valid_q || out_ready);
	assign cfg_ready = 1'b1;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ofta_pkg::S_LOAD: begin
				if (in_acc && in_data.last_sample) state_nxt = ofta_pkg::S_THRESH;
			end
			ofta_pkg::S_THRESH:    state_nxt = ofta_pkg::S_SCAN;
			ofta_pkg::S_SCAN: begin
				if (scan_done) state_nxt = ofta_pkg::S_DIV_PLAIN;
			end
			ofta_pkg::S_DIV_PLAIN: begin
				if (div_done) state_nxt = ofta_pkg::S_DIV_FILT;
			end
			ofta_pkg::S_DIV_FILT: begin
				if (div_done) state_nxt = ofta_pkg::S_DIV_PCT;
			end
			ofta_pkg::S_DIV_PCT: begin
				if (div_done) state_nxt = ofta_pkg::S_FINISH;
			end
			ofta_pkg::S_FINISH: begin
				if (load_out) state_nxt = ofta_pkg::S_LOAD;
			end
			default:               state_nxt = ofta_pkg::S_LOAD;
		endcase
	end

	// controller outputs and divider operands
	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		div_num   = {sum_q, {ofta_pkg::FRAC_W{1'b0}}};
		div_den   = cnt_q;
		case (state_q)
			ofta_pkg::S_LOAD:      in_ready = 1'b1;
			ofta_pkg::S_SCAN:      div_start = scan_done;
			ofta_pkg::S_DIV_PLAIN: begin
				div_start = div_done;
				div_num   = {fsum_q, {ofta_pkg::FRAC_W{1'b0}}};
				div_den   = kept;
			end
			ofta_pkg::S_DIV_FILT: begin
				div_start = div_done;
				div_num   = DIV_W'(outl_q) * DIV_W'(ofta_pkg::PCT_SCALE);
				div_den   = cnt_q;
			end
			default: begin
				in_ready  = 1'b0;
				div_start = 1'b0;
			end
		endcase
	end

	ofta_div #(
		.NUM_W(DIV_W),
		.DEN_W(CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sample memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (in_acc && has_room) begin
			mem[cnt_q[ADDR_W-1:0]] <= in_data.sample_time;
		end
		rd_data_s1 <= mem[rd_idx_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ofta_pkg::S_LOAD;
			factor_q    <= ofta_pkg::FACTOR_RESET;
			min_q       <= '1;
			cnt_q       <= '0;
			sum_q       <= '0;
			drop_q      <= 1'b0;
			rd_idx_q    <= '0;
			rd_pend_s1  <= 1'b0;
			outl_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid && cfg_ready) factor_q <= cfg_data;

			if (in_acc) begin
				if (has_room) begin
					cnt_q <= cnt_q + 1'b1;
					sum_q <= sum_q + SUM_W'(in_data.sample_time);
					if (in_data.sample_time < min_q) min_q <= in_data.sample_time;
				end else begin
					drop_q <= 1'b1;
				end
			end

			rd_pend_s1 <= rd_issue;
			if (state_q == ofta_pkg::S_THRESH) begin
				rd_idx_q <= '0;
				outl_q   <= '0;
			end else begin
				if (rd_issue) rd_idx_q <= rd_idx_q + 1'b1;
				if (rd_pend_s1 && ({{(TW-SW){1'b0}}, rd_data_s1} >= thresh_q)) begin
					outl_q <= outl_q + 1'b1;
				end
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load_out) begin
				// start the next set from scratch
				min_q  <= '1;
				cnt_q  <= '0;
				sum_q  <= '0;
				drop_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ofta_pkg::S_THRESH) begin
			thresh_q <= TW'(factor_q) * TW'(min_q);
			fsum_q   <= '0;
		end else if (rd_pend_s1 && ({{(TW-SW){1'b0}}, rd_data_s1} < thresh_q)) begin
			fsum_q <= fsum_q + SUM_W'(rd_data_s1);
		end

		if (div_done) begin
			case (state_q)
				ofta_pkg::S_DIV_PLAIN:
					plain_q <= (cnt_q == '0) ? '0 : div_quo[ofta_pkg::MEAN_W-1:0];
				ofta_pkg::S_DIV_FILT:
					filt_q <= (kept == '0) ? '0 : div_quo[ofta_pkg::MEAN_W-1:0];
				ofta_pkg::S_DIV_PCT:
					pct_q <= (cnt_q == '0) ? '0 : div_quo[ofta_pkg::PCT_W-1:0];
				default: ;
			endcase
		end

		if (load_out) begin
			out_q.plain_mean      <= plain_q;
			out_q.filtered_mean   <= filt_q;
			out_q.filtered_valid  <= (kept != '0);
			out_q.outlier_count   <= ofta_pkg::COUNT_OUT_W'(outl_q);
			out_q.outlier_percent <= pct_q;
			out_q.overflow        <= drop_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	a_rose_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ofta_pkg::S_FINISH))
		else $error("result word appeared outside the finish step");

	a_full_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !has_room) |=> drop_q)
		else $error("sample past capacity not flagged");

	// the count of the previous set lingers until the threshold step clears it
	a_outl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ofta_pkg::S_LOAD && state_q != ofta_pkg::S_THRESH)
		|-> (outl_q <= cnt_q))
		else $error("outlier count exceeds sample count");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ofta_pkg::S_DIV_PLAIN || state_q == ofta_pkg::S_DIV_FILT
			|| state_q == ofta_pkg::S_DIV_PCT))
		else $error("divider finished outside a divide step");

endmodule

`default_nettype wire

// ----- bench/outlier_filtered_timing_average_test.sv -----
// ----------------------------------------------------------------------------
// outlier_filtered_timing_average_test: self-checking bench for the filter
// Streams sample sets through the block and predicts each set's result from a
// local copy of the set state: minimum, sum, stored samples and dropped flag.
// Directed sets cover the field extremes, the threshold boundary, all-outlier
// sets and a full store. Random sets follow under several factor settings
// and sender/receiver idle mixes. Every result word is checked field by field.
// ----------------------------------------------------------------------------

module outlier_filtered_timing_average_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY      = ofta_pkg::MAX_SAMPLES_DEF;
	localparam int CLK_PERIOD    = 8;
	localparam int SETTLE_CYCLES = 300;
	localparam int PHASE_ITEMS   = 220;
	localparam int PRINT_LIMIT   = 100;
	localparam longint LIMIT_CYCLES = 1500000;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	ofta_pkg::in_word_t            in_data   = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	ofta_pkg::out_word_t           out_data;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [ofta_pkg::FACTOR_W-1:0] cfg_data  = '0;

	outlier_filtered_timing_average #(
		.MAX_SAMPLES(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Predicted set state
	logic [ofta_pkg::SAMPLE_W-1:0] held_times [CAPACITY];
	logic [ofta_pkg::SAMPLE_W-1:0] held_min     = '1;
	int unsigned                   held_count   = 0;
	logic [37:0]                   held_sum     = '0;
	logic                          held_dropped = 1'b0;
	logic [ofta_pkg::FACTOR_W-1:0] factor_reg   = ofta_pkg::FACTOR_RESET;

	ofta_pkg::out_word_t expected_results [$];
	int unsigned error_count    = 0;
	int unsigned results_seen   = 0;
	int unsigned items_sent     = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("Verification failed");
		$finish;
	end

	task automatic report_error(string msg);
		if (error_count < PRINT_LIMIT) begin
			$display("ERROR @%0t: %s", $realtime, msg);
		end
		error_count++;
	endtask

	function automatic logic [ofta_pkg::MEAN_W-1:0] fixed_mean(logic [37:0] total,
		int unsigned n);
		logic [63:0] scaled;
		scaled = {26'd0, total} << ofta_pkg::FRAC_W;
		if (n == 0) begin
			return '0;
		end
		return ofta_pkg::MEAN_W'(scaled / 64'(n));
	endfunction

	// Absorb one accepted word; on the marked sample, push the set's result.
	function void absorb_sample(ofta_pkg::in_word_t w);
		logic [ofta_pkg::THRESH_W-1:0] threshold;
		logic [37:0]                   kept_sum;
		int unsigned                   outliers;
		int unsigned                   kept;
		ofta_pkg::out_word_t           r;
		if (held_count < CAPACITY) begin
			held_times[held_count] = w.sample_time;
			held_count++;
			held_sum += w.sample_time;
			if (w.sample_time < held_min) begin
				held_min = w.sample_time;
			end
		end else begin
			held_dropped = 1'b1;
		end
		if (!w.last_sample) begin
			return;
		end
		threshold = factor_reg * held_min;
		outliers  = 0;
		kept_sum  = '0;
		for (int i = 0; i < held_count; i++) begin
			if ({{ofta_pkg::FACTOR_W{1'b0}}, held_times[i]} >= threshold) begin
				outliers++;
			end else begin
				kept_sum += held_times[i];
			end
		end
		kept = held_count - outliers;
		r.plain_mean      = fixed_mean(held_sum, held_count);
		r.filtered_mean   = (kept != 0) ? fixed_mean(kept_sum, kept) : '0;
		r.filtered_valid  = (kept != 0);
		r.outlier_count   = outliers[ofta_pkg::COUNT_OUT_W-1:0];
		r.outlier_percent = (held_count != 0) ?
			ofta_pkg::PCT_W'((ofta_pkg::PCT_SCALE * outliers) / held_count) : '0;
		r.overflow        = held_dropped;
		expected_results.push_back(r);
		held_min     = '1;
		held_count   = 0;
		held_sum     = '0;
		held_dropped = 1'b0;
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			absorb_sample(in_data);
		end
	end

	// Receiver: stall at random and check each taken word against the oldest prediction.
	always @(posedge clk) begin
		ofta_pkg::out_word_t want;
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_error($sformatf("unexpected result word 0x%0h", out_data));
			end else begin
				want = expected_results.pop_front();
				if (out_data.plain_mean !== want.plain_mean)
					report_error($sformatf("result %0d plain_mean 0x%0h, want 0x%0h",
						results_seen, out_data.plain_mean, want.plain_mean));
				if (out_data.filtered_mean !== want.filtered_mean)
					report_error($sformatf("result %0d filtered_mean 0x%0h, want 0x%0h",
						results_seen, out_data.filtered_mean, want.filtered_mean));
				if (out_data.filtered_valid !== want.filtered_valid)
					report_error($sformatf("result %0d filtered_valid %0b, want %0b",
						results_seen, out_data.filtered_valid, want.filtered_valid));
				if (out_data.outlier_count !== want.outlier_count)
					report_error($sformatf("result %0d outlier_count %0d, want %0d",
						results_seen, out_data.outlier_count, want.outlier_count));
				if (out_data.outlier_percent !== want.outlier_percent)
					report_error($sformatf("result %0d outlier_percent %0d, want %0d",
						results_seen, out_data.outlier_percent, want.outlier_percent));
				if (out_data.overflow !== want.overflow)
					report_error($sformatf("result %0d overflow %0b, want %0b",
						results_seen, out_data.overflow, want.overflow));
			end
			results_seen++;
		end
	end

	task automatic send_sample(logic [ofta_pkg::SAMPLE_W-1:0] t, logic last);
		ofta_pkg::in_word_t w;
		w.sample_time = t;
		w.last_sample = last;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic end_stream();
		in_valid <= 1'b0;
	endtask

	// Wait out the last result and any evaluation still running.
	task automatic settle_block();
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_factor(logic [ofta_pkg::FACTOR_W-1:0] f);
		cfg_valid <= 1'b1;
		cfg_data  <= f;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		factor_reg = f;
	endtask

	function automatic logic [ofta_pkg::SAMPLE_W-1:0] clamp_time(logic [39:0] v,
		logic [ofta_pkg::SAMPLE_W-1:0] floor_v);
		if (v > 40'hFFFF_FFFF) begin
			v = 40'hFFFF_FFFF;
		end
		return (v[31:0] < floor_v) ? floor_v : v[31:0];
	endfunction

	task automatic send_random_set();
		int unsigned                   len;
		int unsigned                   shape;
		int unsigned                   pick;
		int unsigned                   pos_min;
		logic [ofta_pkg::SAMPLE_W-1:0] base;
		logic [ofta_pkg::SAMPLE_W-1:0] t;
		logic [39:0]                   thr;
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			len = $urandom_range(1, 16);
		end else if (pick < 93) begin
			len = $urandom_range(17, CAPACITY);
		end else begin
			len = $urandom_range(CAPACITY + 1, CAPACITY + 12);
		end
		shape   = $urandom_range(0, 99);
		base    = $urandom >> $urandom_range(0, 31);
		pos_min = $urandom_range(0, len - 1);
		thr     = factor_reg * base;
		for (int i = 0; i < len; i++) begin
			if (shape < 60) begin
				// cluster around a planted minimum, with outliers on and near the threshold
				if (i == pos_min) begin
					t = base;
				end else begin
					case ($urandom_range(0, 5))
						0: t = clamp_time(thr, base);
						1: t = clamp_time(thr - 1, base);
						2: t = clamp_time(thr + (base * $urandom_range(0, 3)), base);
						default: t = clamp_time(base + ($urandom % ({8'd0, base} / 2 + 1)), base);
					endcase
				end
			end else if (shape < 80) begin
				t = $urandom;
			end else if (shape < 90) begin
				t = (i == pos_min) ? '0 : ($urandom >> $urandom_range(0, 31));
			end else begin
				t = $urandom_range(0, 15);
			end
			send_sample(t, i == len - 1);
		end
	endtask

	task automatic test_directed_cases();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// single zero sample: minimum zero, so it is its own outlier
		send_sample(32'd0, 1'b1);
		send_sample(32'hFFFF_FFFF, 1'b1);
		// threshold boundary at the reset factor
		send_sample(32'd10, 1'b0);
		send_sample(32'd29, 1'b0);
		send_sample(32'd30, 1'b0);
		send_sample(32'd31, 1'b1);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'h8000_0000, 1'b1);
		send_sample(32'd5, 1'b0);
		send_sample(32'd0, 1'b0);
		send_sample(32'd7, 1'b1);
		end_stream();
		settle_block();
		// factor one: every sample reaches the minimum
		write_factor(4'd1);
		send_sample(32'd7, 1'b0);
		send_sample(32'd7, 1'b0);
		send_sample(32'd9, 1'b1);
		end_stream();
		settle_block();
		// factor zero: threshold is zero
		write_factor(4'd0);
		send_sample(32'd1, 1'b0);
		send_sample(32'd2, 1'b1);
		end_stream();
		settle_block();
		write_factor(4'd15);
		send_sample(32'd1, 1'b0);
		send_sample(32'd14, 1'b0);
		send_sample(32'd15, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b1);
		end_stream();
	endtask

	task automatic test_store_capacity();
		settle_block();
		write_factor(4'd2);
		// exactly full, then two past full with the marked sample dropped
		for (int i = 0; i < CAPACITY; i++) begin
			send_sample($urandom >> $urandom_range(0, 31), i == CAPACITY - 1);
		end
		for (int i = 0; i < CAPACITY + 2; i++) begin
			send_sample($urandom >> $urandom_range(0, 31), i == CAPACITY + 1);
		end
		end_stream();
	endtask

	task automatic test_random_sets();
		int unsigned                   start;
		logic [ofta_pkg::FACTOR_W-1:0] f;
		for (int p = 0; p < 8; p++) begin
			settle_block();
			case (p)
				0: f = 4'd3;
				1: f = 4'd15;
				2: f = 4'd1;
				3: f = 4'd2;
				default: f = $urandom_range(0, 15);
			endcase
			write_factor(f);
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 60;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 60;
				end
				default: begin
					send_idle_pct  = 36;
					recv_stall_pct = 36;
				end
			endcase
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				send_random_set();
			end
			end_stream();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_store_capacity();
		test_random_sets();
		settle_block();
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
